// ----- rtl/pba_pkg.sv -----
// Shared types and constants of the port bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

  // Table size and bitmap word size; WORD_BITS must be a power of two.
  localparam int NUM_PORTS = 8192;
  localparam int WORD_BITS = 64;

  localparam int MAP_WORDS = (NUM_PORTS + WORD_BITS - 1) / WORD_BITS;
  localparam int PORT_W    = $clog2(NUM_PORTS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIDX_W    = PORT_W - BIT_W;
  localparam int RAM_AW    = WIDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  localparam logic [15:0] RESET_BOTTOM = 16'd1024;
  localparam logic [15:0] RESET_TOP    = 16'd4999;

  typedef enum logic [1:0] {
    OP_CLAIM   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ALLOC   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_NOFREE  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_RANGE_BOTTOM = 1'b0,
    CFG_RANGE_TOP    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  op;
    logic        protocol;
    logic [15:0] port;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_port;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/pba_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/port_bitmap_allocator_core.sv -----
// Top level of the port bitmap allocator: TCP/UDP busy maps in one RAM, next-fit search.
//
// Claims, releases and allocates port numbers. Both busy bitmaps sit in one RAM of
// WORD_BITS-wide words, the protocol selecting the upper half. Claim and release
// pass a modify state on the word read at acceptance, then the final state, which
// loads the result register (read, then modify; the write back goes out with the
// result). Allocate reads one bitmap word per cycle through the single RAM read
// port, first from the next-fit pointer up to range_top and then, if nothing is
// free, from range_bottom. Each pass sets up its window in a search state, then
// tests its words in the scan state. The input stays stalled until the result is
// loaded, so the next transaction is taken in the cycle after that at the earliest;
// a result that still waits in the output register holds the final step until the
// result side takes it. After reset the RAM is swept to zero, one word per cycle,
// during which no input is accepted; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module port_bitmap_allocator_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pba_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pba_pkg::out_item_t     out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [0:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i
);
  import pba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SRCH,
    S_SCAN,
    S_FIN
  } state_e;

  state_e               state_q;
  logic [RAM_AW-1:0]    clr_cnt_q;
  logic [15:0]          bottom_q, top_q, ptr_q;
  logic [1:0]           op_q;
  logic                 proto_q;
  logic [15:0]          port_q;
  logic                 pass_q;
  logic [PORT_W-1:0]    lo_q, hi_q;
  logic [WIDX_W-1:0]    chk_w_q;
  logic                 wr_pend_q;
  logic [RAM_AW-1:0]    waddr_q;
  logic [WORD_BITS-1:0] wdata_q;
  logic [1:0]           res_st_q;
  logic [15:0]          res_port_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, rdata;

  pba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(RAM_DEPTH)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  // Search window of the current pass.
  logic [15:0]       from16;
  logic              from_ok;
  logic [PORT_W-1:0] from_tab, to_tab;

  always_comb begin
    from16   = pass_q ? bottom_q : ptr_q;
    from_ok  = (from16 <= top_q) && ({1'b0, from16} < 17'(NUM_PORTS));
    from_tab = from16[PORT_W-1:0];
    to_tab   = ({1'b0, top_q} > 17'(NUM_PORTS - 1)) ? PORT_W'(NUM_PORTS - 1)
                                                     : top_q[PORT_W-1:0];
  end

  // Free bits of the word under test, limited to the window.
  logic [WORD_BITS-1:0] lo_mask, hi_mask, free_v;
  logic [BIT_W-1:0]     free_idx;
  logic                 free_any;
  logic [WIDX_W-1:0]    chk_nxt;
  logic [PORT_W-1:0]    found_port;
  logic [16:0]          nxt_ptr;

  always_comb begin
    lo_mask = '1;
    hi_mask = '1;
    if (chk_w_q == lo_q[PORT_W-1:BIT_W]) begin
      lo_mask = {WORD_BITS{1'b1}} << lo_q[BIT_W-1:0];
    end
    if (chk_w_q == hi_q[PORT_W-1:BIT_W]) begin
      hi_mask = {WORD_BITS{1'b1}} >> (~hi_q[BIT_W-1:0]);
    end
    free_v   = ~rdata & lo_mask & hi_mask;
    free_any = |free_v;
    free_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        free_idx = BIT_W'(i);
      end
    end
    chk_nxt    = chk_w_q + WIDX_W'(1);
    found_port = {chk_w_q, free_idx};
    nxt_ptr    = {1'b0, 16'(found_port)} + 17'd1;
  end

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr_q;
    ram_wdata = wdata_q;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      S_FIN: ram_we = wr_pend_q;
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    case (state_q)
      S_IDLE:  ram_raddr = {in_data_i.protocol, in_data_i.port[PORT_W-1:BIT_W]};
      S_SRCH:  ram_raddr = {proto_q, from_tab[PORT_W-1:BIT_W]};
      S_SCAN:  ram_raddr = {proto_q, chk_nxt};
      default: ram_raddr = {proto_q, port_q[PORT_W-1:BIT_W]};
    endcase
  end

  logic                 slot_free;
  logic                 cur_bit;
  logic [WORD_BITS-1:0] port_onehot;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cur_bit     = rdata[port_q[BIT_W-1:0]];
  assign port_onehot = WORD_BITS'(1) << port_q[BIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      bottom_q    <= RESET_BOTTOM;
      top_q       <= RESET_TOP;
      ptr_q       <= RESET_BOTTOM;
      op_q        <= '0;
      proto_q     <= 1'b0;
      port_q      <= '0;
      pass_q      <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      chk_w_q     <= '0;
      wr_pend_q   <= 1'b0;
      waddr_q     <= '0;
      wdata_q     <= '0;
      res_st_q    <= '0;
      res_port_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_RANGE_BOTTOM: bottom_q <= cfg_data_i;
          CFG_RANGE_TOP:    top_q    <= cfg_data_i;
          default:          top_q    <= top_q;
        endcase
      end

      // drop the result once taken, unless the final step reloads it
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + RAM_AW'(1);
          if (&clr_cnt_q) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid_i) begin
            op_q       <= in_data_i.op;
            proto_q    <= in_data_i.protocol;
            port_q     <= in_data_i.port;
            res_port_q <= in_data_i.port;
            pass_q     <= 1'b0;
            wr_pend_q  <= 1'b0;
            res_st_q   <= ST_INVALID;
            case (in_data_i.op)
              OP_CLAIM, OP_RELEASE: begin
                if ({1'b0, in_data_i.port} < 17'(NUM_PORTS)) begin
                  state_q <= S_MOD;
                end else begin
                  state_q <= S_FIN;
                end
              end
              OP_ALLOC: state_q <= S_SRCH;
              default:  state_q <= S_FIN;
            endcase
          end
        end

        S_MOD: begin
          waddr_q <= {proto_q, port_q[PORT_W-1:BIT_W]};
          state_q <= S_FIN;
          if (op_q == OP_CLAIM) begin
            if (cur_bit) begin
              res_st_q <= ST_BUSY;
            end else begin
              res_st_q  <= ST_OK;
              wdata_q   <= rdata | port_onehot;
              wr_pend_q <= 1'b1;
            end
          end else if (cur_bit) begin
            res_st_q  <= ST_OK;
            wdata_q   <= rdata & ~port_onehot;
            wr_pend_q <= 1'b1;
          end else begin
            res_st_q <= ST_INVALID;
          end
        end

        S_SRCH: begin
          if (from_ok) begin
            lo_q    <= from_tab;
            hi_q    <= to_tab;
            chk_w_q <= from_tab[PORT_W-1:BIT_W];
            state_q <= S_SCAN;
          end else if (!pass_q) begin
            pass_q <= 1'b1;
          end else begin
            res_st_q <= (bottom_q > top_q) ? ST_INVALID : ST_NOFREE;
            state_q  <= S_FIN;
          end
        end

        S_SCAN: begin
          if (free_any) begin
            // claim the lowest free bit and advance the pointer past it
            res_st_q   <= ST_OK;
            res_port_q <= 16'(found_port);
            waddr_q    <= {proto_q, chk_w_q};
            wdata_q    <= rdata | (WORD_BITS'(1) << free_idx);
            wr_pend_q  <= 1'b1;
            ptr_q      <= nxt_ptr[16] ? bottom_q : nxt_ptr[15:0];
            state_q    <= S_FIN;
          end else if (chk_w_q == hi_q[PORT_W-1:BIT_W]) begin
            if (!pass_q) begin
              pass_q  <= 1'b1;
              state_q <= S_SRCH;
            end else begin
              res_st_q <= (bottom_q > top_q) ? ST_INVALID : ST_NOFREE;
              state_q  <= S_FIN;
            end
          end else begin
            chk_w_q <= chk_nxt;
          end
        end

        S_FIN: begin
          if (slot_free) begin
            out_valid_q       <= 1'b1;
            out_q.status      <= res_st_q;
            out_q.result_port <= res_port_q;
            wr_pend_q         <= 1'b0;
            state_q           <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_SCAN || state_q == S_SRCH) |-> !ram_we)
    else $error("bitmap written outside write-back");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result loaded outside final state");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction taken while one is in flight");

  a_scan_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (lo_q <= hi_q))
    else $error("scan window empty");

endmodule
`default_nettype wire
